// ===== rtl/tmat_pkg.sv =====
package tmat_pkg;

  // Field widths of the request and response transactions.
  localparam int OP_W         = 2;
  localparam int MAC_W        = 48;
  localparam int KIND_W       = 3;
  localparam int TAG_W        = 32;
  localparam int STATUS_W     = 3;
  localparam int SLOT_INDEX_W = 6;

  localparam int DEFAULT_TABLE_ENTRIES = 64;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  // Kind codes.
  localparam logic [KIND_W-1:0] KIND_ANY  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_LAST = 3'd4;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UPDATED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ABSENT  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_INVALID = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

  // One word of the table store.
  typedef struct packed {
    logic              valid;
    logic [MAC_W-1:0]  mac;
    logic [KIND_W-1:0] kind;
    logic [TAG_W-1:0]  payload;
  } entry_t;

  // Control from the sequencer to the scan unit.
  typedef struct packed {
    logic restart;
    logic sample;
  } scan_ctl_t;

  // Running results of a scan.
  typedef struct packed {
    logic              hit;
    logic [KIND_W-1:0] hit_kind;
    logic [TAG_W-1:0]  hit_payload;
    logic              free_seen;
  } scan_res_t;

endpackage

// ===== rtl/tmat_scan_unit.sv =====
module tmat_scan_unit #(
  parameter int TABLE_ENTRIES = tmat_pkg::DEFAULT_TABLE_ENTRIES
) (
  input  logic                              clk,
  input  logic                              rst,
  input  tmat_pkg::scan_ctl_t               ctl,
  input  logic [$clog2(TABLE_ENTRIES)-1:0]  cmp_idx,
  input  logic [tmat_pkg::MAC_W-1:0]        req_mac,
  input  logic [tmat_pkg::KIND_W-1:0]       req_kind,
  input  tmat_pkg::entry_t                  rd_entry,
  output tmat_pkg::scan_res_t               res,
  output logic [$clog2(TABLE_ENTRIES)-1:0]  hit_idx,
  output logic [$clog2(TABLE_ENTRIES)-1:0]  free_idx
);

  logic mac_match;
  logic take_hit;
  logic take_free;

  // A wildcard keeps the lowest kind seen, the earliest slot on a tie; a
  // specific kind keeps the first slot that holds it.
  always_comb begin
    mac_match = rd_entry.valid && (rd_entry.mac == req_mac);
    if (req_kind == tmat_pkg::KIND_ANY) begin
      take_hit = mac_match && (!res.hit || (rd_entry.kind < res.hit_kind));
    end else begin
      take_hit = mac_match && (rd_entry.kind == req_kind) && !res.hit;
    end
    take_free = !rd_entry.valid && !res.free_seen;
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.restart) begin
      res.hit       <= 1'b0;
      res.free_seen <= 1'b0;
    end else if (ctl.sample) begin
      if (take_hit) begin
        res.hit         <= 1'b1;
        res.hit_kind    <= rd_entry.kind;
        res.hit_payload <= rd_entry.payload;
        hit_idx         <= cmp_idx;
      end
      if (take_free) begin
        res.free_seen <= 1'b1;
        free_idx      <= cmp_idx;
      end
    end
  end

endmodule

// ===== rtl/typed_mac_address_table.sv =====
// Typed MAC address table.
//
// A request transaction is taken at a rising clock edge at which start is
// high and busy is low; operation, mac_address, entry_kind and payload_tag
// are sampled there. Lookup, insert and remove each cause exactly one
// response transaction, shown on status, found_kind, found_payload and
// slot_index for a single cycle while done is high.
//
// Every well-formed request scans all TABLE_ENTRIES slots through one
// compare unit, one slot per cycle from a store with a registered read
// port. The response follows the scan, the last compare and the commit
// step, and busy falls in the same cycle that it arrives, so a new
// request is not taken before the last is answered. A malformed request
// (zero MAC, unknown kind or operation, wildcard on insert or remove) is
// answered in the cycle after it is taken, and busy stays low.
//
// After reset the block sweeps the store and marks every slot free, with
// busy high. The receiver cannot hold a response off, so done is a
// one-cycle strobe and must be captured then.
module typed_mac_address_table #(
  parameter int TABLE_ENTRIES = tmat_pkg::DEFAULT_TABLE_ENTRIES
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [tmat_pkg::OP_W-1:0]         operation,
  input  logic [tmat_pkg::MAC_W-1:0]        mac_address,
  input  logic [tmat_pkg::KIND_W-1:0]       entry_kind,
  input  logic [tmat_pkg::TAG_W-1:0]        payload_tag,
  output logic                              done,
  output logic [tmat_pkg::STATUS_W-1:0]     status,
  output logic [tmat_pkg::KIND_W-1:0]       found_kind,
  output logic [tmat_pkg::TAG_W-1:0]        found_payload,
  output logic [tmat_pkg::SLOT_INDEX_W-1:0] slot_index
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  // Sequencer states: sweep after reset, wait, scan, last compare, commit.
  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_SCAN   = 5'b00100,
    S_WAIT   = 5'b01000,
    S_COMMIT = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  logic [IDX_W-1:0] scan_cnt;
  logic             cmp_valid;
  logic [IDX_W-1:0] cmp_idx;

  // Request held for the length of a scan.
  logic [tmat_pkg::OP_W-1:0]   req_op;
  logic [tmat_pkg::MAC_W-1:0]  req_mac;
  logic [tmat_pkg::KIND_W-1:0] req_kind;
  logic [tmat_pkg::TAG_W-1:0]  req_tag;

  logic accept;
  logic req_bad;

  // Table store: one write and one registered read a cycle.
  tmat_pkg::entry_t mem [TABLE_ENTRIES];
  tmat_pkg::entry_t rd_entry;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  tmat_pkg::entry_t wr_data;

  tmat_pkg::scan_ctl_t scan_ctl;
  tmat_pkg::scan_res_t scan_res;
  logic [IDX_W-1:0]    hit_idx;
  logic [IDX_W-1:0]    free_idx;

  // Response of the commit step.
  logic [tmat_pkg::STATUS_W-1:0] c_status;
  logic [tmat_pkg::KIND_W-1:0]   c_kind;
  logic [tmat_pkg::TAG_W-1:0]    c_payload;
  logic [IDX_W-1:0]              c_idx;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Malformed requests never reach the scan.
  always_comb begin
    req_bad = (mac_address == '0) || (entry_kind > tmat_pkg::KIND_LAST);
    if ((operation != tmat_pkg::OP_LOOKUP) && (operation != tmat_pkg::OP_INSERT) &&
        (operation != tmat_pkg::OP_REMOVE)) begin
      req_bad = 1'b1;
    end
    if ((operation != tmat_pkg::OP_LOOKUP) && (entry_kind == tmat_pkg::KIND_ANY)) begin
      req_bad = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (scan_cnt == LAST_IDX) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept && !req_bad) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_cnt == LAST_IDX) begin
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      scan_cnt  <= '0;
      cmp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cmp_valid <= (state == S_SCAN);
      if ((state == S_CLEAR) || (state == S_SCAN)) begin
        scan_cnt <= (scan_cnt == LAST_IDX) ? '0 : scan_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= scan_cnt;
    if (accept) begin
      req_op   <= operation;
      req_mac  <= mac_address;
      req_kind <= entry_kind;
      req_tag  <= payload_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_entry <= mem[scan_cnt];
  end

  assign scan_ctl.restart = accept;
  assign scan_ctl.sample  = cmp_valid;

  tmat_scan_unit #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .ctl      (scan_ctl),
    .cmp_idx  (cmp_idx),
    .req_mac  (req_mac),
    .req_kind (req_kind),
    .rd_entry (rd_entry),
    .res      (scan_res),
    .hit_idx  (hit_idx),
    .free_idx (free_idx)
  );

  // Commit: decide the response and the at most one store write of the request.
  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = scan_cnt;
    wr_data   = '0;
    c_status  = tmat_pkg::ST_OK;
    c_kind    = '0;
    c_payload = '0;
    c_idx     = '0;
    if (state == S_CLEAR) begin
      wr_en = 1'b1;
    end else if (state == S_COMMIT) begin
      if (req_op == tmat_pkg::OP_INSERT) begin
        if (scan_res.hit) begin
          // Existing pair: only the payload changes.
          wr_en     = 1'b1;
          wr_addr   = hit_idx;
          wr_data   = '{valid: 1'b1, mac: req_mac, kind: req_kind, payload: req_tag};
          c_status  = tmat_pkg::ST_UPDATED;
          c_kind    = req_kind;
          c_payload = req_tag;
          c_idx     = hit_idx;
        end else if (scan_res.free_seen) begin
          wr_en     = 1'b1;
          wr_addr   = free_idx;
          wr_data   = '{valid: 1'b1, mac: req_mac, kind: req_kind, payload: req_tag};
          c_kind    = req_kind;
          c_payload = req_tag;
          c_idx     = free_idx;
        end else begin
          c_status = tmat_pkg::ST_FULL;
        end
      end else begin
        if (scan_res.hit) begin
          c_kind    = scan_res.hit_kind;
          c_payload = scan_res.hit_payload;
          c_idx     = hit_idx;
        end
        if (req_op == tmat_pkg::OP_REMOVE) begin
          // Removing an absent pair still succeeds.
          wr_en   = scan_res.hit;
          wr_addr = hit_idx;
        end else if (!scan_res.hit) begin
          c_status = tmat_pkg::ST_ABSENT;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (accept && req_bad) || (state == S_COMMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && req_bad) begin
      status        <= tmat_pkg::ST_INVALID;
      found_kind    <= '0;
      found_payload <= '0;
      slot_index    <= '0;
    end else if (state == S_COMMIT) begin
      status        <= c_status;
      found_kind    <= c_kind;
      found_payload <= c_payload;
      slot_index    <= tmat_pkg::SLOT_INDEX_W'(c_idx);
    end
  end

endmodule
